// File: hdl/srlc_pkg.sv
// Package for the selective repeat link controller: codes, field widths, window constants.
// Used by the interfaces and all modules; depends on nothing.
package srlc_pkg;
  localparam int MaxSequence = 31;
  localparam int PacketBytes = 256;
  localparam int SeqW = 5;
  localparam int SlotW = 4;
  localparam int LenW = 9;
  localparam logic [SeqW-1:0] Win = 5'd16;

  localparam logic [2:0] OP_PACKET = 3'd0;
  localparam logic [2:0] OP_PHYS = 3'd1;
  localparam logic [2:0] OP_FRAME = 3'd2;
  localparam logic [2:0] OP_DTMO = 3'd3;
  localparam logic [2:0] OP_ATMO = 3'd4;

  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_DELIVER = 3'd1;
  localparam logic [2:0] ACT_STOP = 3'd2;
  localparam logic [2:0] ACT_START_ACK = 3'd3;
  localparam logic [2:0] ACT_STATUS = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_NAK = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic frame_good;
    logic [1:0] frame_kind;
    logic [SeqW-1:0] frame_seq;
    logic [SeqW-1:0] cum_ack;
    logic [LenW-1:0] frame_length;
    logic [SlotW-1:0] timer_slot;
  } evt_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] send_kind;
    logic [SeqW-1:0] send_seq;
    logic [SeqW-1:0] send_ack;
    logic [SlotW-1:0] buffer_slot;
    logic [LenW-1:0] deliver_length;
    logic network_enable;
    logic last;
  } res_t;

  // command from front to back: op class and pre-computed operands
  typedef struct packed {
    evt_t evt;
    logic [LenW-1:0] dlen;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIRST, ST_DELIV, ST_NAKSEND, ST_STOPW, ST_STATUS
  } bst_t;

  function automatic logic in_win(logic [SeqW-1:0] lo, logic [SeqW-1:0] x,
                                  logic [SeqW-1:0] hi);
    return (lo <= x && x < hi) || (hi < lo && x >= lo) || (hi < lo && x < hi);
  endfunction
endpackage

// File: hdl/srlc_if.sv
// Valid/ready channel interfaces for events and results.
// Depends on srlc_pkg.
interface srlc_evt_if (input logic clk);
  logic valid;
  logic ready;
  srlc_pkg::evt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srlc_res_if (input logic clk);
  logic valid;
  logic ready;
  srlc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/srlc_front.sv
// Front part: accepts events, clamps delivery length, queues commands (2 deep).
// Depends on srlc_pkg.
module srlc_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  srlc_pkg::evt_t in_data,
  output logic cmd_valid,
  input  logic cmd_take,
  output srlc_pkg::cmd_t cmd_data
);
  srlc_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wr_r, rd_r;
  logic [srlc_pkg::LenW-1:0] len;
  srlc_pkg::cmd_t cin;
  logic push, pop;

  always_comb begin
    if (in_data.frame_length > 9'd263) len = 9'(srlc_pkg::PacketBytes);
    else if (in_data.frame_length > 9'd7) len = in_data.frame_length - 9'd7;
    else len = '0;
    cin.evt = in_data;
    cin.dlen = len;
  end

  assign in_ready = cnt_r != 2'd2;
  assign push = in_valid && in_ready;
  assign pop = cmd_take && cmd_valid;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd_data = q_r[rd_r];
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wr_r <= 1'b0; rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
    if (push) q_r[wr_r] <= cin;
  end
endmodule

// File: hdl/srlc_back.sv
// Back part: window state and action sequencer; results go into an output register.
// Depends on srlc_pkg.
module srlc_back (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_take,
  input  srlc_pkg::cmd_t cmd_data,
  output logic out_valid,
  input  logic out_ready,
  output srlc_pkg::res_t out_data
);
  localparam logic [srlc_pkg::SeqW-1:0] One = 5'd1;
  srlc_pkg::bst_t st_r, st_nxt;
  srlc_pkg::cmd_t c_r, c_nxt;
  logic [4:0] swl_r, swl_nxt, swn_r, swn_nxt, rwl_r, rwl_nxt, rwh_r, rwh_nxt;
  logic [4:0] oc_r, oc_nxt;
  logic [15:0] arr_r, arr_nxt;
  logic nak_r, nak_nxt, phy_r, phy_nxt;
  logic [4:0] steps_r, steps_nxt;
  logic ov_r, ov_nxt;
  srlc_pkg::res_t od_r, od_nxt;
  logic can_emit;
  srlc_pkg::res_t r;
  logic [4:0] tseq;

  assign out_valid = ov_r;
  assign out_data = od_r;
  assign can_emit = !ov_r || out_ready;

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; swl_nxt = swl_r; swn_nxt = swn_r;
    rwl_nxt = rwl_r; rwh_nxt = rwh_r; oc_nxt = oc_r; arr_nxt = arr_r;
    nak_nxt = nak_r; phy_nxt = phy_r; steps_nxt = steps_r;
    ov_nxt = ov_r && !out_ready; od_nxt = od_r;
    cmd_take = 1'b0;
    r = '0;
    tseq = {1'b0, c_r.evt.timer_slot};
    if (!srlc_pkg::in_win(swl_r, tseq, swn_r)) tseq = tseq + srlc_pkg::Win;
    case (st_r)
      srlc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1; c_nxt = cmd_data; st_nxt = srlc_pkg::ST_FIRST;
        end
      end
      srlc_pkg::ST_FIRST: if (can_emit) begin
        st_nxt = srlc_pkg::ST_STATUS;
        r.action = srlc_pkg::ACT_SEND;
        r.send_ack = rwl_r - One;
        case (c_r.evt.operation)
          srlc_pkg::OP_PACKET: if (oc_r < srlc_pkg::Win && phy_r) begin
            oc_nxt = oc_r + One;
            r.send_seq = swn_r; r.buffer_slot = swn_r[3:0];
            swn_nxt = swn_r + One; phy_nxt = 1'b0;
            ov_nxt = 1'b1; od_nxt = r;
          end
          srlc_pkg::OP_PHYS: phy_nxt = 1'b1;
          srlc_pkg::OP_DTMO: begin
            r.send_seq = tseq; r.buffer_slot = tseq[3:0];
            phy_nxt = 1'b0; ov_nxt = 1'b1; od_nxt = r;
          end
          srlc_pkg::OP_ATMO: begin
            r.send_kind = srlc_pkg::KIND_ACK;
            phy_nxt = 1'b0; ov_nxt = 1'b1; od_nxt = r;
          end
          srlc_pkg::OP_FRAME: begin
            steps_nxt = '0;
            if (!c_r.evt.frame_good) begin
              if (nak_r) begin
                r.send_kind = srlc_pkg::KIND_NAK; nak_nxt = 1'b0;
                phy_nxt = 1'b0; ov_nxt = 1'b1; od_nxt = r;
              end
            end else if (c_r.evt.frame_kind == srlc_pkg::KIND_DATA) begin
              if (c_r.evt.frame_seq != rwl_r && nak_r) begin
                r.send_kind = srlc_pkg::KIND_NAK; nak_nxt = 1'b0; phy_nxt = 1'b0;
              end else begin
                r = '0; r.action = srlc_pkg::ACT_START_ACK;
              end
              ov_nxt = 1'b1; od_nxt = r;
              st_nxt = srlc_pkg::ST_STOPW;
              if (srlc_pkg::in_win(rwl_r, c_r.evt.frame_seq, rwh_r) &&
                  !arr_r[c_r.evt.frame_seq[3:0]]) begin
                arr_nxt[c_r.evt.frame_seq[3:0]] = 1'b1;
                st_nxt = srlc_pkg::ST_DELIV;
              end
            end else if (c_r.evt.frame_kind == srlc_pkg::KIND_NAK) begin
              st_nxt = srlc_pkg::ST_NAKSEND;
            end else st_nxt = srlc_pkg::ST_STOPW;
          end
          default: ;
        endcase
      end
      srlc_pkg::ST_DELIV: begin
        if (steps_r == srlc_pkg::Win || !arr_r[rwl_r[3:0]]) begin
          st_nxt = srlc_pkg::ST_STOPW; steps_nxt = '0;
        end else if (can_emit) begin
          r.action = srlc_pkg::ACT_DELIVER; r.buffer_slot = rwl_r[3:0];
          r.deliver_length = c_r.dlen;
          ov_nxt = 1'b1; od_nxt = r;
          nak_nxt = 1'b1; arr_nxt[rwl_r[3:0]] = 1'b0;
          rwl_nxt = rwl_r + One; rwh_nxt = rwh_r + One;
          steps_nxt = steps_r + One;
        end
      end
      srlc_pkg::ST_NAKSEND: if (can_emit) begin
        st_nxt = srlc_pkg::ST_STOPW;
        if (srlc_pkg::in_win(swl_r, c_r.evt.cum_ack + One, swn_r)) begin
          r.action = srlc_pkg::ACT_SEND; r.send_seq = c_r.evt.cum_ack + One;
          r.send_ack = rwl_r - One; r.buffer_slot = r.send_seq[3:0];
          phy_nxt = 1'b0; ov_nxt = 1'b1; od_nxt = r;
        end
      end
      srlc_pkg::ST_STOPW: begin
        if (steps_r == srlc_pkg::Win ||
            !srlc_pkg::in_win(swl_r, c_r.evt.cum_ack, swn_r)) begin
          st_nxt = srlc_pkg::ST_STATUS;
        end else if (can_emit) begin
          if (oc_r != '0) oc_nxt = oc_r - One;
          r.action = srlc_pkg::ACT_STOP; r.buffer_slot = swl_r[3:0];
          ov_nxt = 1'b1; od_nxt = r;
          swl_nxt = swl_r + One; steps_nxt = steps_r + One;
        end
      end
      srlc_pkg::ST_STATUS: if (can_emit) begin
        r.action = srlc_pkg::ACT_STATUS; r.last = 1'b1;
        r.network_enable = oc_r < srlc_pkg::Win && phy_r;
        ov_nxt = 1'b1; od_nxt = r; st_nxt = srlc_pkg::ST_IDLE;
      end
      default: st_nxt = srlc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= srlc_pkg::ST_IDLE; swl_r <= '0; swn_r <= '0; rwl_r <= '0;
      rwh_r <= srlc_pkg::Win; oc_r <= '0; arr_r <= '0; nak_r <= 1'b1;
      phy_r <= 1'b0; steps_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; swl_r <= swl_nxt; swn_r <= swn_nxt; rwl_r <= rwl_nxt;
      rwh_r <= rwh_nxt; oc_r <= oc_nxt; arr_r <= arr_nxt; nak_r <= nak_nxt;
      phy_r <= phy_nxt; steps_r <= steps_nxt; ov_r <= ov_nxt;
    end
    c_r <= c_nxt; od_r <= od_nxt;
  end
endmodule

// File: hdl/selective_repeat_link_control.sv
// Top level of the selective repeat link controller.
// Depends on srlc_pkg, srlc_if, srlc_front, srlc_back.
//
// Usage: one link event per transfer on the in_ channel (packet ready,
// physical ready, frame received, data timeout, ack timeout). Each event
// yields a run of action items on the out_ channel, closed by a status item
// with last set and the network-enable bit.
// An event is taken from the two-entry queue into the sequencer's command
// register once the sequencer is idle; its first action is then registered
// in the output register and offered from there.
// An event is first taken, then makes its first step, one further step per
// action and one at each walk exit. The longest event is a frame that
// delivers 16 slots and acks 16 (34 actions); the delivery and ack walks
// of the back sequencer set it. A new event waits until the last is done.
// The front queue keeps accepting events while the back is busy until full.
// Reset (synchronous, rst_n low) clears windows, counts, arrival marks and
// the queue. When the receiver stalls, the output register holds its item
// and the sequencer waits; no item is lost or repeated.
module selective_repeat_link_control (
  input logic clk,
  input logic rst_n,
  srlc_evt_if.sink in_ch,
  srlc_res_if.source out_ch
);
  logic cmd_valid, cmd_take;
  srlc_pkg::cmd_t cmd_data;

  srlc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_data(cmd_data)
  );

  srlc_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd_data(cmd_data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
  );
endmodule

// File: sim/selective_repeat_link_control_tb.sv
`timescale 1ns / 1ps
// Testbench for the selective repeat link controller: directed and random link events,
// with a behavioral predictor of the windows. Depends on srlc_pkg, srlc_if and the RTL.
module selective_repeat_link_control_tb;
  localparam int WinN = 16;
  localparam int SeqMod = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  srlc_evt_if evt_ch (clk);
  srlc_res_if res_ch (clk);

  selective_repeat_link_control u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(evt_ch.sink), .out_ch(res_ch.source)
  );

  // predictor state
  logic [4:0] snd_lo, snd_nx, rcv_lo, rcv_hi, outstanding;
  logic [WinN-1:0] arrived;
  logic nak_ok, phy_rdy;

  srlc_pkg::res_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int events_sent = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  bit hold_sink = 1'b0;

  function automatic bit win_has(logic [4:0] lo, logic [4:0] x, logic [4:0] hi);
    return (lo <= x && x < hi) || (hi < lo && x >= lo) || (hi < lo && x < hi);
  endfunction

  function automatic void push_res(logic [2:0] act, logic [1:0] kind, logic [4:0] seq,
                                   logic [3:0] slot, logic [8:0] len);
    srlc_pkg::res_t r;
    r = '0;
    r.action = act;
    r.send_kind = kind;
    r.send_seq = seq;
    r.buffer_slot = slot;
    r.deliver_length = len;
    if (act == srlc_pkg::ACT_SEND) r.send_ack = rcv_lo - 5'd1;
    expected_q.push_back(r);
  endfunction

  function automatic void push_frame(logic [1:0] kind, logic [4:0] seq);
    if (kind == srlc_pkg::KIND_NAK) nak_ok = 1'b0;
    push_res(srlc_pkg::ACT_SEND, kind, seq, (kind == srlc_pkg::KIND_DATA) ? seq[3:0] : 4'd0,
             '0);
    phy_rdy = 1'b0;
  endfunction

  function automatic void link_reset();
    snd_lo = '0; snd_nx = '0; rcv_lo = '0; rcv_hi = 5'd16; outstanding = '0;
    arrived = '0; nak_ok = 1'b1; phy_rdy = 1'b0;
  endfunction

  function automatic void predict_link_event(srlc_pkg::evt_t e);
    logic [8:0] len;
    logic [4:0] want, s;
    int steps;
    srlc_pkg::res_t st;
    case (e.operation)
      srlc_pkg::OP_PACKET: if (outstanding < WinN && phy_rdy) begin
        outstanding++;
        push_frame(srlc_pkg::KIND_DATA, snd_nx);
        snd_nx++;
      end
      srlc_pkg::OP_PHYS: phy_rdy = 1'b1;
      srlc_pkg::OP_FRAME: begin
        if (!e.frame_good) begin
          if (nak_ok) push_frame(srlc_pkg::KIND_NAK, '0);
        end else begin
          if (e.frame_kind == srlc_pkg::KIND_DATA) begin
            len = (e.frame_length > 7) ? e.frame_length - 9'd7 : '0;
            if (len > srlc_pkg::PacketBytes) len = 9'(srlc_pkg::PacketBytes);
            if (e.frame_seq != rcv_lo && nak_ok) push_frame(srlc_pkg::KIND_NAK, '0);
            else push_res(srlc_pkg::ACT_START_ACK, '0, '0, '0, '0);
            if (win_has(rcv_lo, e.frame_seq, rcv_hi) && !arrived[e.frame_seq[3:0]]) begin
              arrived[e.frame_seq[3:0]] = 1'b1;
              steps = 0;
              while (steps < WinN && arrived[rcv_lo[3:0]]) begin
                push_res(srlc_pkg::ACT_DELIVER, '0, '0, rcv_lo[3:0], len);
                nak_ok = 1'b1;
                arrived[rcv_lo[3:0]] = 1'b0;
                rcv_lo++;
                rcv_hi++;
                steps++;
              end
            end
          end else if (e.frame_kind == srlc_pkg::KIND_NAK) begin
            want = e.cum_ack + 5'd1;
            if (win_has(snd_lo, want, snd_nx)) push_frame(srlc_pkg::KIND_DATA, want);
          end
          steps = 0;
          while (steps < WinN && win_has(snd_lo, e.cum_ack, snd_nx)) begin
            if (outstanding > 0) outstanding--;
            push_res(srlc_pkg::ACT_STOP, '0, '0, snd_lo[3:0], '0);
            snd_lo++;
            steps++;
          end
        end
      end
      srlc_pkg::OP_DTMO: begin
        s = {1'b0, e.timer_slot};
        if (!win_has(snd_lo, s, snd_nx)) s = s + 5'd16;
        push_frame(srlc_pkg::KIND_DATA, s);
      end
      srlc_pkg::OP_ATMO: push_frame(srlc_pkg::KIND_ACK, '0);
      default: ;
    endcase
    st = '0;
    st.action = srlc_pkg::ACT_STATUS;
    st.network_enable = (outstanding < WinN) && phy_rdy;
    st.last = 1'b1;
    expected_q.push_back(st);
  endfunction

  // send one event; prediction happens at the transfer edge, valid stays up
  // until the next call or a drain drops it
  task automatic send_event(srlc_pkg::evt_t e);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    evt_ch.data <= e;
    evt_ch.valid <= 1'b1;
    do @(posedge clk); while (!evt_ch.ready);
    predict_link_event(e);
    events_sent++;
    @(negedge clk);
  endtask

  function automatic srlc_pkg::evt_t mk(logic [2:0] op, logic good = 1'b1,
                                        logic [1:0] kind = srlc_pkg::KIND_DATA,
                                        logic [4:0] seq = 0, logic [4:0] ack = 0,
                                        logic [8:0] flen = 9'd100, logic [3:0] slot = 0);
    srlc_pkg::evt_t e;
    e.operation = op; e.frame_good = good; e.frame_kind = kind; e.frame_seq = seq;
    e.cum_ack = ack; e.frame_length = flen; e.timer_slot = slot;
    return e;
  endfunction

  function automatic srlc_pkg::evt_t rand_evt();
    srlc_pkg::evt_t e;
    e = srlc_pkg::evt_t'({$urandom, $urandom});
    if (e.frame_length > 263) e.frame_length = 9'($urandom_range(0, 263));
    e.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 9) == 0) e.frame_kind = 2'd3;
    else if (e.frame_kind == 2'd3) e.frame_kind = srlc_pkg::KIND_DATA;
    return e;
  endfunction

  task automatic wait_drained();
    evt_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    srlc_pkg::res_t exp_r;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, res_ch.data);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_ch.data !== exp_r) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_r, res_ch.data);
          errors++;
        end
      end
    end
  end

  // receiver ready, with random stalls or a long hold
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        res_ch.ready <= 1'b0;
        repeat (120) @(negedge clk);
        hold_sink = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_event(mk(srlc_pkg::OP_PACKET));            // disabled, ignored
    send_event(mk(srlc_pkg::OP_PHYS));
    send_event(mk(srlc_pkg::OP_PACKET));
    send_event(mk(srlc_pkg::OP_PHYS));
    send_event(mk(srlc_pkg::OP_PACKET));
    send_event(mk(3'd7));                           // unknown op
    send_event(mk(srlc_pkg::OP_FRAME, 1'b0));       // bad frame: nak
    send_event(mk(srlc_pkg::OP_FRAME, 1'b0));       // nak already sent
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_DATA, 5'd2, 5'd31, 9'd0));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_DATA, 5'd1, 5'd31, 9'd263));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_DATA, 5'd0, 5'd31, 9'd7));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_NAK, 5'd0, 5'd31, 9'd5));
    send_event(mk(srlc_pkg::OP_DTMO, 1'b1, srlc_pkg::KIND_DATA, 0, 0, 0, 4'd15));
    send_event(mk(srlc_pkg::OP_DTMO, 1'b1, srlc_pkg::KIND_DATA, 0, 0, 0, 4'd0));
    send_event(mk(srlc_pkg::OP_ATMO));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_ACK, 5'd0, 5'd1, 9'd262));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, 2'd3, 5'd31, 5'd0, 9'd8));
    wait_drained();
  endtask

  // fill the send window, then a big receive walk that delivers 16 slots
  task automatic test_full_windows();
    int i;
    for (i = 0; i < 17; i++) begin
      send_event(mk(srlc_pkg::OP_PHYS));
      send_event(mk(srlc_pkg::OP_PACKET));
    end
    for (i = 1; i < 16; i++)
      send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_DATA, rcv_lo + i[4:0], 5'd31,
                    9'd200));
    send_event(mk(srlc_pkg::OP_FRAME, 1'b1, srlc_pkg::KIND_DATA, rcv_lo, snd_nx - 5'd1,
                  9'd200));
    wait_drained();
  endtask

  // long receiver stall while events keep coming
  task automatic test_backpressure();
    int i;
    hold_sink = 1'b1;
    for (i = 0; i < 12; i++) send_event(rand_evt());
    wait_drained();
  endtask

  // mostly well-formed traffic with random content
  task automatic test_random(int n);
    int i;
    int r;
    srlc_pkg::evt_t e;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) e = mk(srlc_pkg::OP_PHYS);
      else if (r < 5) e = mk(srlc_pkg::OP_PACKET);
      else if (r < 8) begin
        e = mk(srlc_pkg::OP_FRAME, $urandom_range(0, 15) != 0,
               $urandom_range(0, 4) == 0 ? srlc_pkg::KIND_NAK : srlc_pkg::KIND_DATA,
               5'(rcv_lo + $urandom_range(0, 3)),
               5'(snd_lo + $urandom_range(0, 4) - 1), 9'($urandom_range(0, 263)));
      end else e = rand_evt();
      send_event(e);
    end
  endtask

  initial begin
    evt_ch.valid = 1'b0;
    evt_ch.data = '0;
    link_reset();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_full_windows();
    test_backpressure();
    test_random(200);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random(40);
    evt_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Covered %0d link events and %0d actions: windows full, long stall, random.",
             events_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: sim.f
hdl/srlc_pkg.sv
hdl/srlc_if.sv
hdl/srlc_front.sv
hdl/srlc_back.sv
hdl/selective_repeat_link_control.sv
sim/selective_repeat_link_control_tb.sv
